[hw/rtl/kbsc_pkg.sv]
package kbsc_pkg;

    localparam int VECTOR_LEN = 50;
    localparam int MIX_PASSES = 125;
    localparam int KEY_DEPTH  = 50;
    localparam int BASE_LEN   = 50;

    localparam int VEC_AW  = $clog2(VECTOR_LEN);
    localparam int VEC_CW  = $clog2(VECTOR_LEN + 1);
    localparam int KEY_AW  = $clog2(KEY_DEPTH);
    localparam int KEY_CW  = $clog2(KEY_DEPTH + 1);
    localparam int BASE_AW = $clog2(BASE_LEN);
    localparam int PASS_W  = $clog2(MIX_PASSES + 1);

    localparam logic [7:0] BASE_TABLE [BASE_LEN] = '{
        8'd192, 8'd100, 8'd14,  8'd173, 8'd151, 8'd169, 8'd181, 8'd102, 8'd38,  8'd40,
        8'd242, 8'd240, 8'd125, 8'd153, 8'd3,   8'd233, 8'd161, 8'd231, 8'd250, 8'd184,
        8'd143, 8'd198, 8'd158, 8'd163, 8'd93,  8'd126, 8'd22,  8'd144, 8'd219, 8'd148,
        8'd129, 8'd116, 8'd172, 8'd51,  8'd233, 8'd33,  8'd89,  8'd159, 8'd18,  8'd44,
        8'd55,  8'd38,  8'd182, 8'd14,  8'd26,  8'd81,  8'd250, 8'd242, 8'd236, 8'd221
    };

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_KEY      = 3'd1,
        CMD_INIT     = 3'd2,
        CMD_ENCIPHER = 3'd3,
        CMD_DECIPHER = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_INIT  = 2'd1,
        ST_EMPTY_KEY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CIPH,
        S_DONE,
        S_VLOAD,
        S_MIX,
        S_IDENT,
        S_SW_A,
        S_SW_B,
        S_SW_C,
        S_SW_D,
        S_INV_RD,
        S_INV_WR
    } t_state;

    typedef struct packed {
        logic       fwd_we;
        logic [7:0] fwd_wa;
        logic [7:0] fwd_wd;
        logic [7:0] fwd_ra;
        logic [7:0] fwd_rb;
        logic       inv_we;
        logic [7:0] inv_wa;
        logic [7:0] inv_wd;
        logic [7:0] inv_ra;
    } t_perm_ctl;

endpackage

[hw/rtl/kbsc_perm.sv]
module kbsc_perm (
    input  logic                 i_clk,
    input  kbsc_pkg::t_perm_ctl  i_ctl,
    output logic [7:0]           o_fwd_qa,
    output logic [7:0]           o_fwd_qb,
    output logic [7:0]           o_inv_q
);

    logic [7:0] fwd_mem [256];
    logic [7:0] inv_mem [256];

    // forward table: one write, two registered reads per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.fwd_we) begin
            fwd_mem[i_ctl.fwd_wa] <= i_ctl.fwd_wd;
        end
        o_fwd_qa <= fwd_mem[i_ctl.fwd_ra];
        o_fwd_qb <= fwd_mem[i_ctl.fwd_rb];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.inv_we) begin
            inv_mem[i_ctl.inv_wa] <= i_ctl.inv_wd;
        end
        o_inv_q <= inv_mem[i_ctl.inv_ra];
    end

endmodule

[hw/rtl/keyed_byte_substitution_cipher.sv]
// key, clear and status-only commands give their word from state S_DONE;
// encipher and decipher likewise give theirs from S_CIPH, after one forward or inverse table read.
// initialize walks the vector load, mix, identity, swap and inverse states; its length is set by the
// swap loop (S_SW_A to S_SW_D) on the single-write forward table; busy stays high throughout.
// the receiver cannot stall: o_done pulses for one cycle per word.
// reset (synchronous, active low) empties the key and marks the tables not ready.
module keyed_byte_substitution_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_data_in,
    input  logic       i_first_of_message,
    output logic       o_done,
    output logic [7:0] o_data_out,
    output logic [1:0] o_status
);

    kbsc_pkg::t_state    r_state, n_state;
    kbsc_pkg::t_perm_ctl ctl;
    kbsc_pkg::t_cmd      cmd;

    logic [7:0] key_mem [kbsc_pkg::KEY_DEPTH];
    logic [7:0] vec_mem [kbsc_pkg::VECTOR_LEN];

    logic [kbsc_pkg::KEY_CW-1:0]  r_kc;
    logic [kbsc_pkg::KEY_AW-1:0]  r_jk;
    logic [kbsc_pkg::VEC_AW-1:0]  r_i;
    logic [kbsc_pkg::VEC_CW-1:0]  r_j;
    logic [kbsc_pkg::VEC_AW-1:0]  r_nm;
    logic [kbsc_pkg::BASE_AW-1:0] r_b;
    logic [kbsc_pkg::PASS_W-1:0]  r_p;
    logic [7:0] r_n, r_acc, r_vq, r_kq, r_oth, r_t, r_vlast, r_chain, r_ch, r_d;
    logic [7:0] r_dout;
    logic [1:0] r_stat;
    logic       r_pv, r_ready, r_enc;

    logic        accept, issue, mix_wr, vec_we;
    logic [7:0]  chn, ciph_out, vec_wd;
    logic [15:0] prod;
    logic [kbsc_pkg::VEC_AW-1:0] vec_wa, vec_ra;
    logic [7:0]  fwd_qa, fwd_qb, inv_q;

    assign cmd    = kbsc_pkg::t_cmd'(i_cmd);
    assign busy   = (r_state != kbsc_pkg::S_IDLE);
    assign accept = start && !busy;
    assign chn    = i_first_of_message ? r_vlast : r_chain;
    assign issue  = (r_j != kbsc_pkg::VEC_CW'(kbsc_pkg::VECTOR_LEN));
    assign mix_wr = (r_state == kbsc_pkg::S_MIX) && !issue && !r_pv;
    assign prod   = r_vq * r_kq;
    assign ciph_out = r_enc ? fwd_qa : (inv_q ^ r_ch);

    kbsc_perm u_perm (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .o_fwd_qa (fwd_qa),
        .o_fwd_qb (fwd_qb),
        .o_inv_q  (inv_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kbsc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = kbsc_pkg::S_DONE;
                    if (cmd == kbsc_pkg::CMD_INIT && r_kc != '0) begin
                        n_state = kbsc_pkg::S_VLOAD;
                    end else if ((cmd == kbsc_pkg::CMD_ENCIPHER ||
                                  cmd == kbsc_pkg::CMD_DECIPHER) && r_ready) begin
                        n_state = kbsc_pkg::S_CIPH;
                    end
                end
            end
            kbsc_pkg::S_CIPH, kbsc_pkg::S_DONE: n_state = kbsc_pkg::S_IDLE;
            kbsc_pkg::S_VLOAD: begin
                if (r_i == kbsc_pkg::VEC_AW'(kbsc_pkg::VECTOR_LEN - 1)) begin
                    n_state = kbsc_pkg::S_MIX;
                end
            end
            kbsc_pkg::S_MIX: begin
                if (mix_wr && r_i == kbsc_pkg::VEC_AW'(kbsc_pkg::VECTOR_LEN - 1)) begin
                    n_state = kbsc_pkg::S_IDENT;
                end
            end
            kbsc_pkg::S_IDENT: begin
                if (r_n == 8'd255) begin
                    n_state = kbsc_pkg::S_SW_A;
                end
            end
            kbsc_pkg::S_SW_A: n_state = kbsc_pkg::S_SW_B;
            kbsc_pkg::S_SW_B: n_state = kbsc_pkg::S_SW_C;
            kbsc_pkg::S_SW_C: n_state = kbsc_pkg::S_SW_D;
            kbsc_pkg::S_SW_D: begin
                if (r_n == 8'd255 && r_p == kbsc_pkg::PASS_W'(kbsc_pkg::MIX_PASSES - 1)) begin
                    n_state = kbsc_pkg::S_INV_RD;
                end else begin
                    n_state = kbsc_pkg::S_SW_A;
                end
            end
            kbsc_pkg::S_INV_RD: n_state = kbsc_pkg::S_INV_WR;
            kbsc_pkg::S_INV_WR: begin
                n_state = (r_n == 8'd255) ? kbsc_pkg::S_DONE : kbsc_pkg::S_INV_RD;
            end
            default: n_state = kbsc_pkg::S_IDLE;
        endcase
    end

    // memory controls and outputs
    always_comb begin
        ctl        = '0;
        vec_we     = 1'b0;
        vec_wa     = r_i;
        vec_wd     = kbsc_pkg::BASE_TABLE[r_b];
        vec_ra     = r_nm;
        o_done     = 1'b0;
        o_data_out = r_dout;
        o_status   = r_stat;
        unique case (r_state)
            kbsc_pkg::S_IDLE: begin
                ctl.fwd_ra = (cmd == kbsc_pkg::CMD_ENCIPHER) ? (i_data_in ^ chn) : i_data_in;
                ctl.inv_ra = i_data_in;
            end
            kbsc_pkg::S_CIPH: begin
                o_done     = 1'b1;
                o_data_out = ciph_out;
            end
            kbsc_pkg::S_DONE: o_done = 1'b1;
            kbsc_pkg::S_VLOAD: vec_we = 1'b1;
            kbsc_pkg::S_MIX: begin
                vec_ra = r_j[kbsc_pkg::VEC_AW-1:0];
                vec_we = mix_wr;
                vec_wd = r_acc;
            end
            kbsc_pkg::S_IDENT: begin
                ctl.fwd_we = 1'b1;
                ctl.fwd_wa = r_n;
                ctl.fwd_wd = r_n;
            end
            kbsc_pkg::S_SW_A: ;
            kbsc_pkg::S_SW_B: begin
                ctl.fwd_ra = r_vq;
                ctl.fwd_rb = r_n;
            end
            kbsc_pkg::S_SW_C: begin
                ctl.fwd_we = 1'b1;
                ctl.fwd_wa = r_oth;
                ctl.fwd_wd = fwd_qb;
            end
            kbsc_pkg::S_SW_D: begin
                ctl.fwd_we = 1'b1;
                ctl.fwd_wa = r_n;
                ctl.fwd_wd = r_t;
            end
            kbsc_pkg::S_INV_RD: ctl.fwd_ra = r_n;
            kbsc_pkg::S_INV_WR: begin
                ctl.inv_we = 1'b1;
                ctl.inv_wa = fwd_qa;
                ctl.inv_wd = r_n;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && cmd == kbsc_pkg::CMD_KEY &&
            r_kc != kbsc_pkg::KEY_CW'(kbsc_pkg::KEY_DEPTH)) begin
            key_mem[r_kc[kbsc_pkg::KEY_AW-1:0]] <= i_data_in;
        end
        r_kq <= key_mem[r_jk];
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            vec_mem[vec_wa] <= vec_wd;
        end
        r_vq <= vec_mem[vec_ra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbsc_pkg::S_IDLE;
            r_kc    <= '0;
            r_chain <= '0;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && cmd == kbsc_pkg::CMD_CLEAR) begin
                r_kc <= '0;
            end else if (accept && cmd == kbsc_pkg::CMD_KEY &&
                         r_kc != kbsc_pkg::KEY_CW'(kbsc_pkg::KEY_DEPTH)) begin
                r_kc <= r_kc + 1'b1;
            end
            if (r_state == kbsc_pkg::S_CIPH) begin
                r_chain <= r_enc ? fwd_qa : r_d;
            end
            if (r_state == kbsc_pkg::S_INV_WR && r_n == 8'd255) begin
                r_ready <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dout <= '0;
            r_stat <= kbsc_pkg::ST_OK;
            r_enc  <= (cmd == kbsc_pkg::CMD_ENCIPHER);
            r_ch   <= chn;
            r_d    <= i_data_in;
            r_i    <= '0;
            r_b    <= '0;
            if (cmd == kbsc_pkg::CMD_INIT && r_kc == '0) begin
                r_stat <= kbsc_pkg::ST_EMPTY_KEY;
            end else if ((cmd == kbsc_pkg::CMD_ENCIPHER ||
                          cmd == kbsc_pkg::CMD_DECIPHER) && !r_ready) begin
                r_stat <= kbsc_pkg::ST_NOT_INIT;
            end
        end
        unique case (r_state)
            kbsc_pkg::S_VLOAD: begin
                r_i <= r_i + 1'b1;
                r_b <= (r_b == kbsc_pkg::BASE_AW'(kbsc_pkg::BASE_LEN - 1)) ? '0 : r_b + 1'b1;
                if (r_i == kbsc_pkg::VEC_AW'(kbsc_pkg::VECTOR_LEN - 1)) begin
                    r_i   <= '0;
                    r_j   <= '0;
                    r_jk  <= '0;
                    r_acc <= '0;
                    r_pv  <= 1'b0;
                end
            end
            kbsc_pkg::S_MIX: begin
                r_pv <= issue;
                if (issue) begin
                    r_j  <= r_j + 1'b1;
                    // key index runs modulo the key length
                    r_jk <= (r_jk == kbsc_pkg::KEY_AW'(r_kc - 1'b1)) ? '0 : r_jk + 1'b1;
                end
                if (r_pv) begin
                    r_acc <= r_acc + prod[7:0];
                end
                if (mix_wr) begin
                    r_acc <= '0;
                    r_j   <= '0;
                    r_jk  <= '0;
                    r_i   <= r_i + 1'b1;
                    r_n   <= '0;
                    if (r_i == kbsc_pkg::VEC_AW'(kbsc_pkg::VECTOR_LEN - 1)) begin
                        r_vlast <= r_acc;
                    end
                end
            end
            kbsc_pkg::S_IDENT: begin
                r_n  <= r_n + 1'b1;
                r_p  <= '0;
                r_nm <= '0;
            end
            kbsc_pkg::S_SW_B: r_oth <= r_vq;
            kbsc_pkg::S_SW_C: r_t <= fwd_qa;
            kbsc_pkg::S_SW_D: begin
                r_n  <= r_n + 1'b1;
                r_nm <= (r_nm == kbsc_pkg::VEC_AW'(kbsc_pkg::VECTOR_LEN - 1)) ? '0 : r_nm + 1'b1;
                if (r_n == 8'd255) begin
                    r_p  <= r_p + 1'b1;
                    r_nm <= '0;
                end
            end
            kbsc_pkg::S_INV_WR: r_n <= r_n + 1'b1;
            default: ;
        endcase
    end

endmodule

[verif/tb_keyed_byte_substitution_cipher.sv]
module tb_keyed_byte_substitution_cipher;
    timeunit 1ns;
    timeprecision 1ps;
    import kbsc_pkg::*;

    localparam int NUM_ROUNDS = 3;
    localparam int ROUND_ITEMS = 340;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_cmd;
    logic [7:0] i_data_in;
    logic       i_first_of_message;
    logic       o_done;
    logic [7:0] o_data_out;
    logic [1:0] o_status;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
    } t_word;

    // predicted state of the cipher
    logic [7:0] key_bytes [KEY_DEPTH];
    int         key_len;
    logic [7:0] key_vec [VECTOR_LEN];
    logic [7:0] fwd_perm [256];
    logic [7:0] inv_perm [256];
    logic [7:0] chain;
    logic       perm_ready;

    t_word expected_words [$];
    int    words_seen;
    int    mismatches;
    int    sent_items;
    int    cipher_items;
    int    init_count;

    keyed_byte_substitution_cipher u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_data_in          (i_data_in),
        .i_first_of_message (i_first_of_message),
        .o_done             (o_done),
        .o_data_out         (o_data_out),
        .o_status           (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void derive_permutation();
        logic [31:0] acc;
        logic [7:0]  other;
        logic [7:0]  t;
        for (int i = 0; i < VECTOR_LEN; i++) key_vec[i] = BASE_TABLE[i % BASE_LEN];
        for (int i = 0; i < VECTOR_LEN; i++) begin
            acc = 0;
            for (int j = 0; j < VECTOR_LEN; j++)
                acc += key_vec[j] * key_bytes[j % key_len];
            key_vec[i] = acc[7:0];
        end
        for (int i = 0; i < 256; i++) fwd_perm[i] = 8'(i);
        for (int p = 0; p < MIX_PASSES; p++) begin
            for (int i = 0; i < 256; i++) begin
                other = key_vec[i % VECTOR_LEN];
                t = fwd_perm[other];
                fwd_perm[other] = fwd_perm[i];
                fwd_perm[i] = t;
            end
        end
        for (int i = 0; i < 256; i++) inv_perm[fwd_perm[i]] = 8'(i);
        perm_ready = 1'b1;
    endfunction

    function automatic t_word cipher_step(logic [2:0] cmd, logic [7:0] d, logic first);
        t_word w;
        w = '0;
        case (cmd)
            CMD_CLEAR: key_len = 0;
            CMD_KEY: begin
                if (key_len < KEY_DEPTH) begin
                    key_bytes[key_len] = d;
                    key_len++;
                end
            end
            CMD_INIT: begin
                if (key_len == 0) w.status = ST_EMPTY_KEY;
                else derive_permutation();
            end
            CMD_ENCIPHER, CMD_DECIPHER: begin
                if (!perm_ready) begin
                    w.status = ST_NOT_INIT;
                end else begin
                    if (first) chain = key_vec[VECTOR_LEN-1];
                    if (cmd == CMD_ENCIPHER) begin
                        w.data = fwd_perm[d ^ chain];
                        chain = w.data;
                    end else begin
                        w.data = inv_perm[d] ^ chain;
                        chain = d;
                    end
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_word exp_w;
        if (i_rst_n && o_done) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data %0d status %0d", o_data_out, o_status);
            end else begin
                exp_w = expected_words.pop_front();
                if (o_data_out !== exp_w.data || o_status !== exp_w.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d mismatch: data exp %0d got %0d, status exp %0d got %0d",
                                 words_seen, exp_w.data, o_data_out, exp_w.status, o_status);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    task automatic send_item(logic [2:0] cmd, logic [7:0] d, logic first);
        @(negedge i_clk);
        start = 1'b1;
        i_cmd = cmd;
        i_data_in = d;
        i_first_of_message = first;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        expected_words.push_back(cipher_step(cmd, d, first));
        sent_items++;
        if (cmd == CMD_ENCIPHER || cmd == CMD_DECIPHER) cipher_items++;
        if (cmd == CMD_INIT && key_len != 0) init_count++;
        idle_cycles(pick_gap());
    endtask

    task automatic drain_words();
        idle_cycles(1);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_not_initialized();
        send_item(CMD_ENCIPHER, 8'h00, 1'b1);
        send_item(CMD_DECIPHER, 8'hFF, 1'b0);
        send_item(3'd5, 8'hA5, 1'b1);
        send_item(3'd6, 8'h5A, 1'b0);
        send_item(3'd7, 8'hFF, 1'b1);
        send_item(CMD_INIT, 8'h00, 1'b0);
        send_item(CMD_KEY, 8'h3C, 1'b1);
        send_item(CMD_CLEAR, 8'hFF, 1'b1);
        // empty key again after clear
        send_item(CMD_INIT, 8'hFF, 1'b1);
    endtask

    task automatic test_single_byte_key();
        send_item(CMD_KEY, 8'hFF, 1'b0);
        send_item(CMD_INIT, 8'h00, 1'b1);
        send_item(CMD_ENCIPHER, 8'h00, 1'b1);
        send_item(CMD_ENCIPHER, 8'hFF, 1'b0);
        send_item(CMD_ENCIPHER, 8'h80, 1'b0);
        send_item(CMD_DECIPHER, 8'h00, 1'b1);
        send_item(CMD_DECIPHER, 8'hFF, 1'b0);
        // tables survive a key clear
        send_item(CMD_CLEAR, 8'h00, 1'b0);
        send_item(CMD_ENCIPHER, 8'h01, 1'b0);
        send_item(CMD_DECIPHER, 8'h7F, 1'b1);
        send_item(3'd7, 8'h00, 1'b0);
    endtask

    task automatic run_message(logic [2:0] cmd, int len);
        for (int i = 0; i < len; i++)
            send_item(cmd, 8'($urandom), i == 0);
    endtask

    task automatic test_random_rounds();
        int n;
        int r;
        int klen;
        for (int round = 0; round < NUM_ROUNDS; round++) begin
            drain_words();
            send_item(CMD_CLEAR, 8'($urandom), 1'($urandom));
            // first round overflows the key store
            klen = (round == 0) ? KEY_DEPTH + 4 : $urandom_range(KEY_DEPTH, 1);
            for (int k = 0; k < klen; k++) send_item(CMD_KEY, 8'($urandom), 1'($urandom));
            send_item(CMD_INIT, 8'($urandom), 1'($urandom));
            n = 0;
            while (n < ROUND_ITEMS) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    klen = $urandom_range(20, 1);
                    run_message(CMD_ENCIPHER, klen);
                    n += klen;
                end else if (r < 85) begin
                    klen = $urandom_range(20, 1);
                    run_message(CMD_DECIPHER, klen);
                    n += klen;
                end else if (r < 90) begin
                    send_item(3'($urandom_range(4, 3)), 8'($urandom), 1'($urandom));
                    n++;
                end else if (r < 94) begin
                    send_item(CMD_KEY, 8'($urandom), 1'($urandom));
                    n++;
                end else if (r < 96) begin
                    send_item(CMD_CLEAR, 8'($urandom), 1'($urandom));
                    send_item(CMD_INIT, 8'($urandom), 1'($urandom));
                    n += 2;
                end else begin
                    send_item(3'($urandom_range(7, 5)), 8'($urandom), 1'($urandom));
                    n++;
                end
            end
        end
    endtask

    initial begin
        start = 1'b0;
        i_cmd = CMD_CLEAR;
        i_data_in = '0;
        i_first_of_message = 1'b0;
        i_rst_n = 1'b0;
        key_len = 0;
        chain = '0;
        perm_ready = 1'b0;
        words_seen = 0;
        mismatches = 0;
        sent_items = 0;
        cipher_items = 0;
        init_count = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_not_initialized();
        drain_words();
        test_single_byte_key();
        test_random_rounds();

        drain_words();
        repeat (20) @(posedge i_clk);
        if (expected_words.size() != 0) mismatches++;
        $display("covered %0d words, %0d of them cipher bytes, %0d table builds",
                 sent_items, cipher_items, init_count);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kbsc_pkg.sv
hw/rtl/kbsc_perm.sv
hw/rtl/keyed_byte_substitution_cipher.sv
verif/tb_keyed_byte_substitution_cipher.sv
